// ===== design/fafp_pkg.sv =====
// shared types, constants and sizes for the framed ascii four field parser
// no dependencies
package fafp_pkg;

    localparam int WINDOW      = 16;
    localparam int FRAME_MAX   = 64;
    localparam int FIELD_CHARS = 3;
    localparam int NUM_FIELDS  = 4;
    localparam int NUM_OUT     = 4;

    localparam int VAL_W   = 11;
    localparam int SUM_W   = 15;
    localparam int BYTE_W  = 8;
    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LEN_W   = $clog2(FRAME_MAX + 2);
    localparam int POS_W   = $clog2(NUM_FIELDS + 2);
    localparam int CHARS_W = $clog2(FIELD_CHARS + 1);
    localparam int TDATA_W = ((NUM_OUT * (VAL_W + SUM_W) + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [BYTE_W-1:0] CH_SEP   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef t_val [NUM_FIELDS-1:0]   t_entry;

    typedef enum logic [2:0] {
        PH_SKIP = 3'b001,
        PH_CONV = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef struct packed {
        logic   valid;
        t_entry vals;
    } t_close;

    typedef struct packed {
        t_entry                  vals;
        t_sum [NUM_FIELDS-1:0]   sums;
    } t_payload;

    typedef struct packed {
        logic     valid;
        t_payload data;
    } t_result;

endpackage

// ===== design/framed_ascii_four_field_parser.sv =====
// top level of the framed ascii four field parser: stream ports and output skid
// depends on fafp_pkg, fafp_parser and fafp_window
//
// usage:
//   slave channel s_axis_* carries one received ascii byte per request in tdata.
//   master channel m_axis_* carries one result per frame closed by ')':
//   four latched field values and four window sums of the last WINDOW frames.
//   bytes outside '(' ... ')' and frames longer than FRAME_MAX bytes give nothing.
// throughput:
//   one byte per cycle while the skid register is empty; the history memory is
//   read every cycle at the ring pointer so the oldest entry is ready at ')'.
// result path:
//   the window registers the result with the ring update after the ')' request,
//   then the output register, or the skid register while stalled, takes it.
// reset:
//   synchronous, active low; clears the parser, the latched values, the sums and
//   the written marks of the history memory, so every window starts at zero.
// stall:
//   an output register and a skid register hold results; s_axis_tready drops
//   only while the skid register is occupied, and no result is ever lost.
module framed_ascii_four_field_parser
    import fafp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // value_a, value_b, value_c, value_d, window_sum_a .. window_sum_d
    output logic [TDATA_W-1:0] m_axis_tdata
);

    logic     in_acc;
    t_close   close_req;
    t_result  res;
    logic     r_out_valid, r_skid_valid;
    t_payload r_out, r_skid;

    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    fafp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_acc),
        .i_byte  (s_axis_tdata),
        .o_close (close_req)
    );

    fafp_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_close  (close_req),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= res.valid;
            end else begin
                r_out_valid <= res.valid;
            end
        end else if (res.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (res.valid) begin
                    r_skid <= res.data;
                end
            end else if (res.valid) begin
                r_out <= res.data;
            end
        end else if (res.valid) begin
            r_skid <= res.data;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < NUM_OUT; i++) begin
            if (i < NUM_FIELDS) begin
                m_axis_tdata[i*VAL_W +: VAL_W]                 = r_out.vals[i];
                m_axis_tdata[NUM_OUT*VAL_W + i*SUM_W +: SUM_W] = r_out.sums[i];
            end
        end
    end

endmodule

// ===== design/fafp_hist_ram.sv =====
// history memory: one write port, one read port with registered read data
// depends on fafp_pkg
module fafp_hist_ram
    import fafp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [PTR_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [PTR_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [WINDOW];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/fafp_parser.sv =====
// per-byte frame and field parser, keeps pending and latched field values
// depends on fafp_pkg; issues one close request per completed frame
module fafp_parser
    import fafp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output t_close            o_close
);

    logic               r_in_frame, n_in_frame;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [POS_W-1:0]   r_pos, n_pos;
    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [CHARS_W-1:0] r_chars, n_chars;
    t_entry             r_pend, n_pend;
    logic [NUM_FIELDS-1:0] r_present, n_present;
    t_entry             r_last, n_last;

    logic [LEN_W-1:0] len_inc;
    logic             is_space, is_digit, is_sign, in_field, upd, close_now;
    logic [3:0]       digit;
    t_val             times10;
    t_entry           latched;

    always_comb begin
        len_inc  = r_len + LEN_W'(1);
        is_space = (i_byte == CH_SPACE) || (i_byte >= CH_TAB && i_byte <= CH_CR);
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        is_sign  = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
        digit    = 4'(i_byte - CH_ZERO);
        in_field = (r_pos != '0) && (r_pos <= POS_W'(NUM_FIELDS)) && (r_phase != PH_DONE);

        for (int i = 0; i < NUM_FIELDS; i++) begin
            latched[i] = r_present[i] ? r_pend[i] : r_last[i];
        end

        n_in_frame = r_in_frame;
        n_len      = r_len;
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_chars    = r_chars;
        n_pend     = r_pend;
        n_present  = r_present;
        n_last     = r_last;
        upd        = 1'b0;
        close_now  = 1'b0;
        times10    = '0;

        if (i_valid) begin
            if (i_byte == CH_OPEN) begin
                n_in_frame = 1'b1;
                n_len      = LEN_W'(1);
                n_pos      = '0;
                n_phase    = PH_SKIP;
                n_neg      = 1'b0;
                n_chars    = '0;
                n_present  = '0;
                n_pend     = '0;
            end else if (r_in_frame) begin
                n_len = len_inc;
                if (len_inc > LEN_W'(FRAME_MAX)) begin
                    n_in_frame = 1'b0;
                end else if (i_byte == CH_CLOSE) begin
                    close_now  = 1'b1;
                    n_in_frame = 1'b0;
                    n_last     = latched;
                end else if (i_byte == CH_SEP) begin
                    if (r_pos <= POS_W'(NUM_FIELDS)) begin
                        n_pos = r_pos + POS_W'(1);
                    end
                    for (int i = 0; i < NUM_FIELDS; i++) begin
                        if (n_pos == POS_W'(i + 1)) begin
                            n_pend[i]    = '0;
                            n_present[i] = 1'b1;
                        end
                    end
                    n_phase = PH_SKIP;
                    n_neg   = 1'b0;
                    n_chars = '0;
                end else if (in_field && !(r_phase == PH_SKIP && is_space)) begin
                    if (r_chars >= CHARS_W'(FIELD_CHARS)) begin
                        n_phase = PH_DONE;
                    end else if (r_phase == PH_SKIP && is_sign) begin
                        n_neg   = (i_byte == CH_MINUS);
                        n_phase = PH_CONV;
                        n_chars = r_chars + CHARS_W'(1);
                    end else if (is_digit) begin
                        upd     = 1'b1;
                        n_phase = PH_CONV;
                        n_chars = r_chars + CHARS_W'(1);
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
        end

        for (int i = 0; i < NUM_FIELDS; i++) begin
            if (upd && r_pos == POS_W'(i + 1)) begin
                times10   = (r_pend[i] <<< 3) + (r_pend[i] <<< 1);
                n_pend[i] = r_neg ? times10 - t_val'({1'b0, digit})
                                  : times10 + t_val'({1'b0, digit});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_len      <= '0;
            r_pos      <= '0;
            r_phase    <= PH_SKIP;
            r_neg      <= 1'b0;
            r_chars    <= '0;
            r_pend     <= '0;
            r_present  <= '0;
            r_last     <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_len      <= n_len;
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_chars    <= n_chars;
            r_pend     <= n_pend;
            r_present  <= n_present;
            r_last     <= n_last;
        end
    end

    assign o_close.valid = close_now;
    assign o_close.vals  = latched;

endmodule

// ===== design/fafp_window.sv =====
// history ring and window sums: reads the oldest entry, replaces it, updates sums
// depends on fafp_pkg and fafp_hist_ram
module fafp_window
    import fafp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_close  i_close,
    output t_result o_result
);

    logic [PTR_W-1:0]  r_ptr;
    logic [WINDOW-1:0] r_written;
    logic              r_old_valid;
    t_entry            rd_data;
    t_entry            old_vals;
    t_sum [NUM_FIELDS-1:0] r_sum, n_sum;
    logic              r_res_valid;
    t_entry            r_res_vals;

    fafp_hist_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (i_close.valid),
        .i_waddr (r_ptr),
        .i_wdata (i_close.vals),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    // entries never written read as zero
    always_comb begin
        old_vals = r_old_valid ? rd_data : '0;
        for (int i = 0; i < NUM_FIELDS; i++) begin
            n_sum[i] = r_sum[i] - SUM_W'(old_vals[i]) + SUM_W'(i_close.vals[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_written   <= '0;
            r_old_valid <= 1'b0;
            r_sum       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_old_valid <= r_written[r_ptr];
            r_res_valid <= i_close.valid;
            if (i_close.valid) begin
                r_written[r_ptr] <= 1'b1;
                r_sum            <= n_sum;
                r_ptr            <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_close.valid) begin
            r_res_vals <= i_close.vals;
        end
    end

    assign o_result.valid     = r_res_valid;
    assign o_result.data.vals = r_res_vals;
    assign o_result.data.sums = r_sum;

endmodule

// ===== sim/tb_framed_ascii_four_field_parser.sv =====
// testbench for framed_ascii_four_field_parser: byte stream in, frame results out
// holds a cycle-free model of the parser and window sums; needs fafp_pkg and the uut
module tb_framed_ascii_four_field_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import fafp_pkg::*;

    typedef struct {
        t_val vals [NUM_FIELDS];
        t_sum sums [NUM_FIELDS];
    } frame_result;

    class frame_board;
        bit          in_frame;
        int unsigned frame_len;
        int unsigned field_pos;
        t_phase      phase;
        bit          negative;
        int unsigned chars;
        bit [31:0]   pend [NUM_FIELDS];
        bit [NUM_FIELDS-1:0] present;
        bit [31:0]   last [NUM_FIELDS];
        bit [31:0]   hist [WINDOW][NUM_FIELDS];
        int unsigned hptr;
        bit [31:0]   sums [NUM_FIELDS];
        frame_result due_results [$];
        int          errors;
        int          frames_checked;

        function new();
            in_frame = 0;
            frame_len = 0;
            field_pos = 0;
            phase = PH_SKIP;
            negative = 0;
            chars = 0;
            present = '0;
            hptr = 0;
            errors = 0;
            frames_checked = 0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                pend[i] = '0;
                last[i] = '0;
                sums[i] = '0;
                for (int w = 0; w < WINDOW; w++) hist[w][i] = '0;
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int outstanding();
            return due_results.size();
        endfunction

        function bit is_ws(logic [BYTE_W-1:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void convert_char(logic [BYTE_W-1:0] c);
            int unsigned f;
            bit [31:0]   d;
            if (field_pos == 0 || field_pos > NUM_FIELDS || phase == PH_DONE) return;
            f = field_pos - 1;
            if (phase == PH_SKIP && is_ws(c)) return;
            if (chars >= FIELD_CHARS) begin
                phase = PH_DONE;
                return;
            end
            if (phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
                negative = (c == CH_MINUS);
                phase = PH_CONV;
                chars++;
                return;
            end
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = {24'b0, c} - {24'b0, CH_ZERO};
                pend[f] = negative ? pend[f] * 10 - d : pend[f] * 10 + d;
                phase = PH_CONV;
                chars++;
                return;
            end
            phase = PH_DONE;
        endfunction

        function void close_frame();
            frame_result r;
            bit [31:0]   old;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                if (present[i]) last[i] = pend[i];
                old = hist[hptr][i];
                hist[hptr][i] = last[i];
                sums[i] = sums[i] - old + last[i];
                r.vals[i] = t_val'(last[i][VAL_W-1:0]);
                r.sums[i] = t_sum'(sums[i][SUM_W-1:0]);
            end
            hptr = (hptr + 1) % WINDOW;
            in_frame = 0;
            due_results.push_back(r);
        endfunction

        // one accepted request on the byte side
        function void take_byte(logic [BYTE_W-1:0] c);
            if (c == CH_OPEN) begin
                in_frame = 1;
                frame_len = 1;
                field_pos = 0;
                phase = PH_SKIP;
                negative = 0;
                chars = 0;
                present = '0;
                for (int i = 0; i < NUM_FIELDS; i++) pend[i] = '0;
                return;
            end
            if (!in_frame) return;
            frame_len++;
            if (frame_len > FRAME_MAX) begin
                in_frame = 0;
                return;
            end
            if (c == CH_CLOSE) begin
                close_frame();
                return;
            end
            if (c == CH_SEP) begin
                if (field_pos <= NUM_FIELDS) field_pos++;
                if (field_pos <= NUM_FIELDS) begin
                    pend[field_pos-1] = '0;
                    present[field_pos-1] = 1'b1;
                end
                phase = PH_SKIP;
                negative = 0;
                chars = 0;
                return;
            end
            convert_char(c);
        endfunction

        task check_result(logic [TDATA_W-1:0] tdata);
            frame_result exp_r;
            t_val        got_v;
            t_sum        got_s;
            if (due_results.size() == 0) begin
                report($sformatf("result with no frame pending, tdata %h", tdata));
                return;
            end
            exp_r = due_results.pop_front();
            frames_checked++;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                got_v = tdata[i*VAL_W +: VAL_W];
                got_s = tdata[NUM_FIELDS*VAL_W + i*SUM_W +: SUM_W];
                if (got_v !== exp_r.vals[i])
                    report($sformatf("frame %0d value_%c got %0d want %0d", frames_checked,
                                     8'h61 + i, got_v, exp_r.vals[i]));
                if (got_s !== exp_r.sums[i])
                    report($sformatf("frame %0d window_sum_%c got %0d want %0d",
                                     frames_checked, 8'h61 + i, got_s, exp_r.sums[i]));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata = '0;   // rx_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // value_a, value_b, value_c, value_d, window_sum_a .. window_sum_d
    logic [TDATA_W-1:0] m_axis_tdata;

    frame_board  board = new();
    int          tx_idle_pct = 26;
    int          rx_idle_pct = 70;
    int          bytes_sent = 0;
    int          frame_bytes = 0;
    logic [BYTE_W-1:0] frame_buf [$];

    framed_ascii_four_field_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    task send_byte(logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_byte(b);
        bytes_sent++;
    endtask

    task send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    function logic [BYTE_W-1:0] pick_ws();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return CH_CR;
        endcase
    endfunction

    function logic [BYTE_W-1:0] pick_junk();
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h41, 8'h7A));
    endfunction

    function void build_field();
        int n;
        frame_buf.push_back(CH_SEP);
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 2);
            repeat (n) frame_buf.push_back(pick_ws());
        end
        case ($urandom_range(0, 5))
            0: frame_buf.push_back(CH_PLUS);
            1: frame_buf.push_back(CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 3);
        repeat (n) frame_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        if ($urandom_range(0, 5) == 0) frame_buf.push_back(pick_junk());
    endfunction

    function void build_frame();
        int nf;
        frame_buf.delete();
        frame_buf.push_back(CH_OPEN);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) frame_buf.push_back(pick_junk());
        nf = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : NUM_FIELDS;
        repeat (nf) build_field();
        if ($urandom_range(0, 39) == 0)
            repeat ($urandom_range(FRAME_MAX - 4, FRAME_MAX + 4))
                frame_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        if ($urandom_range(0, 19) != 0) frame_buf.push_back(CH_CLOSE);
    endfunction

    initial begin
        int target;
        int wait_cycles;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored bytes, extremes, whitespace, signs, empty and missing fields
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("x)#5");
        send_text("(#999#-99#+9#0)");
        send_text("(ab#\011\012\013\014\015 -12#+3#007#12a)");
        send_text("(####)");
        send_text("(#1234#- 5#-#+)");
        send_text("(#7)");
        send_text("(#1#2(#3#4#5#6)");
        send_text("(#1");
        repeat (FRAME_MAX) send_byte(CH_ZERO);
        send_text(")#2)");
        drain_results();

        target = 1200;
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 70 : 0;
            rx_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 26 : 0;
            while (frame_bytes < target * (ph + 1) / 3) begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                build_frame();
                foreach (frame_buf[i]) send_byte(frame_buf[i]);
                frame_bytes += frame_buf.size();
            end
            drain_results();
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (board.outstanding() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        while (board.outstanding() != 0) begin
            void'(board.due_results.pop_front());
            board.report("frame result never arrived");
        end

        $display("sent %0d bytes (%0d in generated frames), checked %0d frame results",
                 bytes_sent, frame_bytes, board.frames_checked);
        $display("idle mixes covered: sender-light/receiver-heavy, reverse, and none");
        if (board.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
